// ===== sv/assert_macros.svh =====
// Assertion helpers included by stable_sorted_priority_queue.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CHK_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CHK_IMPLY_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CHK_ALWAYS(lbl, clk, rst, prop, msg)

`define CHK_IMPLY_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/sspq_pkg.sv =====
`timescale 1ns / 1ps

package sspq_pkg;

   localparam int CAPACITY   = 16;
   localparam int LEVEL_BITS = 16;

   // Width of the level field on the ports.
   localparam int LEVEL_FIELD_BITS = 16;
   localparam int PAYLOAD_BITS     = 32;
   localparam int OCC_BITS         = 5;

   // A level is kept at most as wide as the field it comes from.
   localparam int STORE_LEVEL_BITS =
      (LEVEL_BITS < LEVEL_FIELD_BITS) ? LEVEL_BITS : LEVEL_FIELD_BITS;

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [PAYLOAD_BITS-1:0]            payload;
      logic signed [STORE_LEVEL_BITS-1:0] level;
   } entry_type;

   // Command broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type fresh;
   } cell_cmd_type;

endpackage

// ===== sv/sspq_cell.sv =====
`timescale 1ns / 1ps

module sspq_cell (
   input  logic                  clock,
   input  sspq_pkg::cell_cmd_type cmd,
   input  logic                  valid,
   input  logic                  left_place,
   input  sspq_pkg::entry_type   left_entry,
   input  sspq_pkg::entry_type   right_entry,
   output logic                  place,
   output sspq_pkg::entry_type   entry
);
   import sspq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // The new entry belongs at or before this cell when the cell is empty or
   // holds a strictly greater level. Equal levels stay ahead for stability.
   assign place = !valid || (entry_ff.level > cmd.fresh.level);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.remove) begin
         entry_in = right_entry;
      end else if (cmd.insert && place) begin
         entry_in = left_place ? left_entry : cmd.fresh;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== sv/stable_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Sorted priority queue with stable ordering among equal levels.
// Request channel (req_): kind selects insert or remove; payload and level
// carry the entry on insert and are ignored on remove.
// Response channel (rsp_): one transaction per request, with a status, the
// removed entry (zero unless a remove succeeded) and the occupancy after
// the operation.
// Entries sit in a chain of cells ordered by level. On insert every cell
// compares its level with the new one and either holds, takes its left
// neighbor, or takes the new entry; on remove every cell but the last takes
// its right neighbor and the last holds. All cells change in the same cycle.
// The response is valid in the cycle after request acceptance, and one
// request is taken every cycle while the response side keeps up.
// When the receiver stalls, the response register holds and req_ready
// drops until the pending response is taken.
// Reset empties the queue at once; no clearing pass is needed.
module stable_sorted_priority_queue (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic                                          req_kind,
   input  logic signed [sspq_pkg::PAYLOAD_BITS-1:0]      req_payload,
   input  logic signed [sspq_pkg::LEVEL_FIELD_BITS-1:0]  req_level,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic [1:0]                                    rsp_status,
   output logic signed [sspq_pkg::PAYLOAD_BITS-1:0]      rsp_removed_payload,
   output logic signed [sspq_pkg::LEVEL_FIELD_BITS-1:0]  rsp_removed_level,
   output logic [sspq_pkg::OCC_BITS-1:0]                 rsp_occupancy
);
   import sspq_pkg::*;

   logic                    accept;
   logic                    full;
   logic                    empty;
   cell_cmd_type            cmd;
   logic [CAPACITY-1:0]     cell_valid;
   logic [CAPACITY-1:0]     cell_place;
   entry_type               cell_entry [CAPACITY];

   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   status_type              status_ff;
   status_type              status_in;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic [PAYLOAD_BITS-1:0] payload_in;
   logic [LEVEL_FIELD_BITS-1:0] level_ff;
   logic [LEVEL_FIELD_BITS-1:0] level_in;
   logic [COUNT_BITS+OCC_BITS-1:0] occ_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == COUNT_BITS'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      cmd.insert        = accept && (req_kind == KIND_INSERT) && !full;
      cmd.remove        = accept && (req_kind == KIND_REMOVE) && !empty;
      cmd.fresh.payload = req_payload;
      cmd.fresh.level   = req_level[STORE_LEVEL_BITS-1:0];
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_valid[i] = (COUNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_head
         sspq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .valid       (cell_valid[i]),
            .left_place  (1'b0),
            .left_entry  (cmd.fresh),
            .right_entry (cell_entry[(i + 1) % CAPACITY]),
            .place       (cell_place[i]),
            .entry       (cell_entry[i])
         );
      end else if (i == CAPACITY - 1) begin : g_tail
         sspq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .valid       (cell_valid[i]),
            .left_place  (cell_place[i-1]),
            .left_entry  (cell_entry[i-1]),
            .right_entry (cell_entry[i]),
            .place       (cell_place[i]),
            .entry       (cell_entry[i])
         );
      end else begin : g_mid
         sspq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .valid       (cell_valid[i]),
            .left_place  (cell_place[i-1]),
            .left_entry  (cell_entry[i-1]),
            .right_entry (cell_entry[i+1]),
            .place       (cell_place[i]),
            .entry       (cell_entry[i])
         );
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      payload_in   = payload_ff;
      level_in     = level_ff;
      if (cmd.insert) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_DONE;
         payload_in   = '0;
         level_in     = '0;
         if (req_kind == KIND_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end
         end else if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            payload_in = cell_entry[0].payload;
            level_in   = LEVEL_FIELD_BITS'(cell_entry[0].level);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      payload_ff <= payload_in;
      level_ff   <= level_in;
   end

   // The occupancy field shows the count modulo its width.
   assign occ_wide            = (COUNT_BITS+OCC_BITS)'(count_ff);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_removed_payload = payload_ff;
   assign rsp_removed_level   = level_ff;
   assign rsp_occupancy       = occ_wide[OCC_BITS-1:0];

`include "assert_macros.svh"

   `CHK_ALWAYS(a_count_bound, clock, reset,
      count_ff <= COUNT_BITS'(CAPACITY), "count above capacity")
   `CHK_IMPLY_NEXT(a_accept_gives_rsp, clock, reset,
      accept, rsp_valid_ff, "no response after request")
   `CHK_ALWAYS(a_fail_zero, clock, reset,
      !(rsp_valid_ff && status_ff != STATUS_DONE) || (payload_ff == '0 && level_ff == '0),
      "failed transaction carries data")
   `CHK_IMPLY_NEXT(a_remove_count, clock, reset,
      cmd.remove, count_ff == $past(count_ff) - COUNT_BITS'(1), "remove did not shrink queue")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import sspq_pkg::*;

   localparam int STALL_LIMIT   = 5000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 310;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [1:0]                    status;
      logic [PAYLOAD_BITS-1:0]       removed_payload;
      logic [LEVEL_FIELD_BITS-1:0]   removed_level;
      logic [OCC_BITS-1:0]           occupancy;
   } queue_outcome_type;

   // Keeps its own sorted copy of the queue and the responses it implies.
   class queue_order_scoreboard;
      logic [PAYLOAD_BITS-1:0] held_payloads[$];
      int                      held_levels[$];
      queue_outcome_type       awaited_responses[$];
      int                      failures;

      function new();
         failures = 0;
      endfunction

      function void predict_request(logic kind, logic [PAYLOAD_BITS-1:0] payload,
                                    logic [LEVEL_FIELD_BITS-1:0] level_field);
         logic signed [STORE_LEVEL_BITS-1:0] narrow;
         int                                 lv;
         int                                 pos;
         queue_outcome_type                  outcome;
         outcome.status          = STATUS_DONE;
         outcome.removed_payload = '0;
         outcome.removed_level   = '0;
         if (kind == KIND_INSERT) begin
            if (held_levels.size() >= CAPACITY) begin
               outcome.status = STATUS_FULL;
            end else begin
               narrow = level_field[STORE_LEVEL_BITS-1:0];
               lv     = int'(narrow);
               pos    = 0;
               // Equal levels go behind the ones already held.
               while (pos < held_levels.size() && held_levels[pos] <= lv) pos++;
               held_levels.insert(pos, lv);
               held_payloads.insert(pos, payload);
            end
         end else begin
            if (held_levels.size() == 0) begin
               outcome.status = STATUS_EMPTY;
            end else begin
               lv                      = held_levels.pop_front();
               outcome.removed_payload = held_payloads.pop_front();
               outcome.removed_level   = lv[LEVEL_FIELD_BITS-1:0];
            end
         end
         outcome.occupancy = OCC_BITS'(held_levels.size());
         awaited_responses.push_back(outcome);
      endfunction

      function void check_response(queue_outcome_type seen);
         queue_outcome_type want;
         if (awaited_responses.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: response with none expected: status %0d payload %h level %h occ %0d",
                        seen.status, seen.removed_payload, seen.removed_level, seen.occupancy);
            return;
         end
         want = awaited_responses.pop_front();
         if (seen !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("ERROR: expected status %0d payload %h level %h occ %0d",
                        want.status, want.removed_payload, want.removed_level, want.occupancy);
               $display("       got      status %0d payload %h level %h occ %0d",
                        seen.status, seen.removed_payload, seen.removed_level, seen.occupancy);
            end
         end
      endfunction

      function int pending();
         return awaited_responses.size();
      endfunction

      function void close_out();
         if (awaited_responses.size() != 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: %0d responses never arrived", awaited_responses.size());
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic                                 req_kind;
   logic signed [PAYLOAD_BITS-1:0]       req_payload;
   logic signed [LEVEL_FIELD_BITS-1:0]   req_level;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [1:0]                           rsp_status;
   logic signed [PAYLOAD_BITS-1:0]       rsp_removed_payload;
   logic signed [LEVEL_FIELD_BITS-1:0]   rsp_removed_level;
   logic [OCC_BITS-1:0]                  rsp_occupancy;

   queue_order_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int quiet_cycles;

   stable_sorted_priority_queue dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_payload         (req_payload),
      .req_level           (req_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_removed_payload (rsp_removed_payload),
      .rsp_removed_level   (rsp_removed_level),
      .rsp_occupancy       (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: a long hold-off counted here, otherwise random backpressure.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.predict_request(req_kind, req_payload, req_level);
         if (rsp_valid && rsp_ready)
            board.check_response('{rsp_status, rsp_removed_payload,
                                   rsp_removed_level, rsp_occupancy});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic kind, logic [PAYLOAD_BITS-1:0] payload,
                               logic [LEVEL_FIELD_BITS-1:0] level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_kind    = kind;
      req_payload = payload;
      req_level   = level;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic run_directed();
      int i;
      send_request(KIND_REMOVE, 32'h1234_5678, 16'h7FFF);
      send_request(KIND_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
      send_request(KIND_INSERT, 32'h8000_0000, 16'h8000);
      send_request(KIND_INSERT, 32'h0000_0000, 16'h0000);
      send_request(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(KIND_INSERT, 32'h0000_0001, 16'h0000);
      // A run of equal levels has to come back out in arrival order.
      for (i = 0; i < 10; i++)
         send_request(KIND_INSERT, 32'hC0DE_0000 + i, 16'h0005);
      send_request(KIND_INSERT, 32'h5555_AAAA, 16'h0001);
      send_request(KIND_INSERT, 32'hAAAA_5555, 16'h8000);
      for (i = 0; i < 5; i++)
         send_request(KIND_REMOVE, $urandom, 16'($urandom));
   endtask

   function automatic logic [LEVEL_FIELD_BITS-1:0] pick_level();
      case ($urandom_range(3))
         0: return LEVEL_FIELD_BITS'($urandom_range(3));
         1: begin
            case ($urandom_range(3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'hFFFF;
               default: return 16'h0000;
            endcase
         end
         default: return LEVEL_FIELD_BITS'($urandom);
      endcase
   endfunction

   task automatic run_random(int count);
      int i;
      int insert_pct;
      insert_pct = 50;
      for (i = 0; i < count; i++) begin
         // Bursts that lean toward inserts or removes reach both full and empty.
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: insert_pct = 15;
               1: insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         if ($urandom_range(99) < insert_pct)
            send_request(KIND_INSERT, $urandom, pick_level());
         else
            send_request(KIND_REMOVE, $urandom, LEVEL_FIELD_BITS'($urandom));
      end
   endtask

   initial begin
      board         = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = 0;
      quiet_cycles  = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_INSERT;
      req_payload   = '0;
      req_level     = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();

      send_idle_pct = 14;
      recv_idle_pct = 65;
      run_random(PHASE_ITEMS);

      send_idle_pct = 65;
      recv_idle_pct = 14;
      run_random(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = LONG_HOLD;
      run_random(PHASE_ITEMS);

      req_valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      board.close_out();
      if (board.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
